FILE: hdl/mssf_pkg.sv
// ----------------------------------------------------------------------------
// mssf_pkg
// Shared types and constants for the median and slew sample filter.
// ----------------------------------------------------------------------------
package mssf_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int WINDOW_LEN = 5;
	localparam int PTR_W      = $clog2(WINDOW_LEN);
	localparam int RANK_W     = $clog2(WINDOW_LEN);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef sample_t [WINDOW_LEN-1:0] window_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [RANK_W-1:0] rank_t;

	localparam ptr_t    PTR_LAST   = PTR_W'(WINDOW_LEN - 1);
	localparam rank_t   MEDIAN_RANK = RANK_W'(WINDOW_LEN / 2);
	localparam sample_t SLEW_RESET = SAMPLE_W'(20);

endpackage

FILE: hdl/mssf_window.sv
// ----------------------------------------------------------------------------
// mssf_window
// Ring window of samples with write pointer and first-fill handling.
// ----------------------------------------------------------------------------
module mssf_window (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              write_en,
	input  mssf_pkg::sample_t sample,
	output mssf_pkg::window_t window_next
);

	mssf_pkg::window_t window_q;
	mssf_pkg::ptr_t    ptr_q;
	logic              filled_q;

	// first sample after reset lands in every slot
	always_comb begin
		for (int i = 0; i < mssf_pkg::WINDOW_LEN; i++) begin
			if (!filled_q || (ptr_q == mssf_pkg::PTR_W'(i))) begin
				window_next[i] = sample;
			end else begin
				window_next[i] = window_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			window_q <= window_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			filled_q <= 1'b0;
		end else if (write_en) begin
			filled_q <= 1'b1;
			if (ptr_q == mssf_pkg::PTR_LAST) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + mssf_pkg::PTR_W'(1);
			end
		end
	end

endmodule

FILE: hdl/mssf_median.sv
// ----------------------------------------------------------------------------
// mssf_median
// Rank-based median select over the window, one comparator per pair.
// ----------------------------------------------------------------------------
module mssf_median (
	input  mssf_pkg::window_t window,
	output mssf_pkg::sample_t median
);

	mssf_pkg::rank_t rank [mssf_pkg::WINDOW_LEN];

	// equal values are ranked by slot so that exactly one slot holds each rank
	always_comb begin
		for (int i = 0; i < mssf_pkg::WINDOW_LEN; i++) begin
			rank[i] = '0;
			for (int j = 0; j < mssf_pkg::WINDOW_LEN; j++) begin
				if ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i))) begin
					rank[i] = rank[i] + mssf_pkg::RANK_W'(1);
				end
			end
		end
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < mssf_pkg::WINDOW_LEN; i++) begin
			if (rank[i] == mssf_pkg::MEDIAN_RANK) begin
				median = median | window[i];
			end
		end
	end

endmodule

FILE: hdl/mssf_slew.sv
// ----------------------------------------------------------------------------
// mssf_slew
// Slew-rate limiter with its step register and last output.
// ----------------------------------------------------------------------------
module mssf_slew (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_cap_we,
	input  mssf_pkg::sample_t step_cap_wdata,
	input  logic              update,
	input  mssf_pkg::sample_t target,
	output mssf_pkg::sample_t limited
);

	mssf_pkg::sample_t step_cap_q;
	mssf_pkg::sample_t last_q;
	logic              started_q;
	logic [mssf_pkg::SAMPLE_W:0] up_lim;
	logic [mssf_pkg::SAMPLE_W:0] down_chk;

	assign up_lim   = {1'b0, last_q} + {1'b0, step_cap_q};
	assign down_chk = {1'b0, target} + {1'b0, step_cap_q};

	// a rise is capped at or below the target, so the narrowing never drops bits
	always_comb begin
		if (!started_q) begin
			limited = target;
		end else if ({1'b0, target} > up_lim) begin
			limited = up_lim[mssf_pkg::SAMPLE_W-1:0];
		end else if (down_chk < {1'b0, last_q}) begin
			limited = last_q - step_cap_q;
		end else begin
			limited = target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cap_q <= mssf_pkg::SLEW_RESET;
			last_q     <= '0;
			started_q  <= 1'b0;
		end else begin
			if (step_cap_we) begin
				step_cap_q <= step_cap_wdata;
			end
			if (update) begin
				last_q    <= limited;
				started_q <= 1'b1;
			end
		end
	end

endmodule

FILE: hdl/median_slew_sample_filter_unit.sv
// ----------------------------------------------------------------------------
// median_slew_sample_filter_unit
// Median-of-window filter followed by a slew-rate limiter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: adc_sample with in_valid / in_ready. Each transfer is one
//   12-bit reading. Output channel: filtered_sample with out_valid /
//   out_ready, one result per input transfer, in order.
//   The step cap is written through step_cap_we / step_cap_wdata, taken at
//   the clock edge with the enable high; write it only while the filter is idle.
//   Data path: a reading is first taken into the input register, and its
//   result is registered once the result register is free or being read.
//   Throughput: one reading per clock while out_ready keeps up; the window
//   update, five-way median rank select and limiter clamp all sit between
//   the input register and the result register.
//   Reset: window empty, pointer at slot zero, limiter not started, step cap
//   back to 20. The first reading after reset fills the whole window and
//   passes the limiter unchanged.
//   Stalls: when out_ready is low the result holds, the input register still
//   takes one more reading, and in_ready then drops until the output moves.
// ----------------------------------------------------------------------------
module median_slew_sample_filter_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [11:0]           adc_sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [11:0]           filtered_sample,
	input  logic                  step_cap_we,
	input  logic [11:0]           step_cap_wdata
);

	mssf_pkg::sample_t sample_s1;
	logic              valid_s1;
	mssf_pkg::sample_t result_q;
	logic              result_valid_q;
	logic              advance;
	mssf_pkg::window_t window_next;
	mssf_pkg::sample_t median;
	mssf_pkg::sample_t limited;

	assign advance  = valid_s1 && (!result_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= adc_sample;
		end
		if (advance) begin
			result_q <= limited;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (out_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	mssf_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_en    (advance),
		.sample      (sample_s1),
		.window_next (window_next)
	);

	mssf_median u_median (
		.window (window_next),
		.median (median)
	);

	mssf_slew u_slew (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_cap_we    (step_cap_we),
		.step_cap_wdata (step_cap_wdata),
		.update         (advance),
		.target         (median),
		.limited        (limited)
	);

	assign out_valid       = result_valid_q;
	assign filtered_sample = result_q;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the median and slew sample filter. Readings go in
// over a valid/ready transfer with random gaps; an in-bench model of the
// window median and slew limiter predicts each filtered sample, and every
// output transfer is compared with the oldest prediction. The step cap is
// rewritten between phases while the filter is idle, covering zero, one,
// the default, full scale and random settings.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_LIMIT = 2000;
	localparam int unsigned MAX_REPORTS = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	mssf_pkg::sample_t adc_sample = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	mssf_pkg::sample_t filtered_sample;
	logic              step_cap_we = 1'b0;
	mssf_pkg::sample_t step_cap_wdata = '0;

	// model of the filter state
	mssf_pkg::sample_t window_copy [mssf_pkg::WINDOW_LEN];
	int unsigned       write_slot = 0;
	bit                window_filled = 1'b0;
	mssf_pkg::sample_t last_output = '0;
	bit                limiter_started = 1'b0;
	mssf_pkg::sample_t slew_setting = mssf_pkg::SLEW_RESET;

	mssf_pkg::sample_t filtered_due [$];
	int unsigned       samples_sent = 0;
	int unsigned       results_seen = 0;
	int unsigned       slew_writes = 0;
	int unsigned       mismatch_count = 0;
	int unsigned       cycle_count = 0;
	bit                steady = 1'b0;
	int                signal_level = 2048;

	median_slew_sample_filter_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_sample(filtered_sample),
		.step_cap_we    (step_cap_we),
		.step_cap_wdata (step_cap_wdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				filtered_due.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input mssf_pkg::sample_t got,
		input mssf_pkg::sample_t wanted);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s got %0d wanted %0d", cycle_count, what,
				got, wanted);
	endtask

	function automatic mssf_pkg::sample_t window_median();
		mssf_pkg::sample_t sorted [mssf_pkg::WINDOW_LEN];
		mssf_pkg::sample_t v;
		int                j;
		for (int i = 0; i < mssf_pkg::WINDOW_LEN; i++)
			sorted[i] = window_copy[i];
		for (int i = 1; i < mssf_pkg::WINDOW_LEN; i++) begin
			v = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		return sorted[mssf_pkg::WINDOW_LEN/2];
	endfunction

	function automatic mssf_pkg::sample_t filter_predict(input mssf_pkg::sample_t s);
		mssf_pkg::sample_t m;
		int unsigned       prev;
		int unsigned       step;
		int unsigned       target;
		// first reading after reset primes every slot
		if (!window_filled) begin
			for (int i = 0; i < mssf_pkg::WINDOW_LEN; i++)
				window_copy[i] = s;
			window_filled = 1'b1;
		end
		window_copy[write_slot] = s;
		write_slot = (write_slot == mssf_pkg::WINDOW_LEN - 1) ? 0 : write_slot + 1;
		m = window_median();
		if (!limiter_started) begin
			limiter_started = 1'b1;
			last_output = m;
			return m;
		end
		prev = last_output;
		step = slew_setting;
		target = m;
		if (target > prev + step)
			prev = prev + step;
		else if (target + step < prev)
			prev = prev - step;
		else
			prev = target;
		last_output = mssf_pkg::sample_t'(prev);
		return last_output;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// output side back-pressure
	initial begin
		int unsigned hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (steady) begin
				out_ready = 1'b1;
				hold = 0;
			end else if (hold == 0) begin
				out_ready = ($urandom_range(0, 99) < 70);
				hold = out_ready ? $urandom_range(0, 12) : pick_gap();
			end else begin
				hold--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (filtered_due.size() == 0)
				report_mismatch("unexpected transfer", filtered_sample, '0);
			else if (filtered_sample !== filtered_due[0]) begin
				report_mismatch("filtered_sample", filtered_sample, filtered_due[0]);
				void'(filtered_due.pop_front());
			end else begin
				void'(filtered_due.pop_front());
			end
		end
	end

	task automatic send_sample(input mssf_pkg::sample_t s);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		adc_sample = s;
		do @(posedge clk); while (!in_ready);
		filtered_due.push_back(filter_predict(s));
		samples_sent++;
	endtask

	// drop valid, let every result out, then let the pipeline settle
	task automatic wait_drained();
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		in_valid = 1'b0;
		while (filtered_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_slew(input mssf_pkg::sample_t value);
		wait_drained();
		step_cap_we = 1'b1;
		step_cap_wdata = value;
		@(negedge clk);
		step_cap_we = 1'b0;
		slew_setting = value;
		slew_writes++;
	endtask

	function automatic mssf_pkg::sample_t random_reading();
		int unsigned r;
		int          v;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			// slowly wandering level with noise
			signal_level += $urandom_range(0, 80) - 40;
			if (signal_level < 0) signal_level = 0;
			if (signal_level > 4095) signal_level = 4095;
			v = signal_level + $urandom_range(0, 16) - 8;
		end else if (r < 65) begin
			// impulse spike, the median should reject lone ones
			case ($urandom_range(0, 2))
				0: v = 0;
				1: v = 4095;
				default: v = $urandom_range(0, 4095);
			endcase
		end else if (r < 85) begin
			v = $urandom_range(0, 4095);
		end else begin
			signal_level = $urandom_range(0, 4095);
			v = signal_level;
		end
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return mssf_pkg::sample_t'(v);
	endfunction

	// first reading fills the window and passes the limiter as it is
	task automatic test_first_fill();
		steady = 1'b0;
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd0);
		send_sample(12'd0);
		send_sample(12'd0);
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd2048);
	endtask

	task automatic test_slew_full_scale();
		write_slew(12'd4095);
		send_sample(12'd4095);
		send_sample(12'd4095);
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd0);
		send_sample(12'd0);
	endtask

	// zero slew holds the output whatever the median does, then a step cap of one is tried
	task automatic test_slew_zero();
		write_slew(12'd0);
		send_sample(12'd4095);
		send_sample(12'd4095);
		send_sample(12'd4095);
		send_sample(12'd1365);
		send_sample(12'd2730);
		write_slew(12'd1);
		send_sample(12'd0);
		send_sample(12'd0);
		send_sample(12'd0);
	endtask

	task automatic test_random_phase(input mssf_pkg::sample_t slew, input int unsigned count,
		input bit no_idle);
		write_slew(slew);
		steady = no_idle;
		repeat (count) send_sample(random_reading());
		steady = 1'b0;
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_first_fill();
		test_slew_full_scale();
		test_slew_zero();

		test_random_phase(12'd20, 80, 1'b0);
		test_random_phase(12'd0, 60, 1'b0);
		test_random_phase(12'd4095, 80, 1'b0);
		test_random_phase(12'd1, 60, 1'b1);
		test_random_phase(mssf_pkg::sample_t'($urandom_range(2, 200)), 100, 1'b0);
		test_random_phase(mssf_pkg::sample_t'($urandom_range(0, 4095)), 60, 1'b1);
		test_random_phase(mssf_pkg::sample_t'($urandom_range(0, 4095)), 60, 1'b0);

		wait_drained();
		repeat (10) @(negedge clk);
		if (filtered_due.size() != 0)
			report_mismatch("results never transferred",
				mssf_pkg::sample_t'(filtered_due.size()), '0);

		$display("run covered %0d readings and %0d filtered results", samples_sent,
			results_seen);
		$display("step cap written %0d times, mismatches %0d", slew_writes,
			mismatch_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
hdl/mssf_pkg.sv
hdl/mssf_window.sv
hdl/mssf_median.sv
hdl/mssf_slew.sv
hdl/median_slew_sample_filter_unit.sv
sim/tb_top.sv
